@@ rtl/frc_pkg.sv @@
// Shared types and constants of the FIFO replacement cache.
`default_nettype none
package frc_pkg;

  localparam int CAPACITY = 15;
  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_PUT    = 2'd1,
    OP_WRITE  = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  // A lookup request as it travels along the row of cells.
  typedef struct packed {
    logic              vld;
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              hit;
    logic [DATA_W-1:0] rdata;
  } frc_req_t;

  // One stored entry.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              sync;
  } frc_entry_t;

endpackage
`default_nettype wire

@@ rtl/fifo_replacement_cache.sv @@
// Top level of the fully associative cache with first-in-first-out replacement.
//
// Requests arrive on the input channel (in_valid_i / in_stall_o) with an
// operation, an address and a data word. Read looks the address up, put
// inserts a clean entry, write updates every held copy and marks it unsynced
// or, on a miss, inserts an unsynced entry. Each request yields exactly one
// result on the output channel (out_valid_o / out_stall_i): hit flag, read
// data, and the oldest entry when an insert into a full cache evicted it.
//
// Entries sit in a row of CAPACITY cells ordered newest first. A request
// walks the row one cell per cycle; once it leaves the last cell its outcome
// is captured, and the commit state shifts the row for an insert and loads
// the output register. The input stays stalled from acceptance until the
// commit, so a new request is not taken before the last one has committed.
// An unused operation code skips the walk and returns an all-zero result.
//
// Reset empties the cache (the entry count goes to zero) and drops any request
// in flight. While the receiver stalls, the result holds in the output
// register; the next request is still accepted and walks the row, and it
// waits in its commit cycle until the output register is free.
`default_nettype none
module fifo_replacement_cache
  import frc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic        [1:0]  op_i,
  input  wire logic signed [31:0] addr_i,
  input  wire logic        [31:0] data_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    hit_o,
  output logic             [31:0] read_data_o,
  output logic                    evicted_o,
  output logic signed      [31:0] evicted_addr_o,
  output logic             [31:0] evicted_data_o,
  output logic                    evicted_sync_o
);

  state_e state_q, state_d;

  // Request held for the whole operation.
  logic [1:0]        op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] data_q;
  logic              hit_q;
  logic [DATA_W-1:0] rdata_q;

  logic [CNT_W-1:0]  count_q, count_d;

  frc_req_t   req_chain [CAPACITY+1];
  frc_entry_t ent_chain [CAPACITY+1];
  logic [CAPACITY-1:0] live;

  logic in_acc, do_commit, do_insert, full, shift;

  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign do_commit  = (state_q == ST_COMMIT) && (!out_valid_o || !out_stall_i);
  assign do_insert  = (op_q == OP_PUT) || ((op_q == OP_WRITE) && !hit_q);
  assign shift      = do_commit && do_insert;

  // A request enters the first cell the cycle it is accepted; unused codes stay out.
  always_comb begin
    req_chain[0].vld   = in_acc && (op_i != OP_UNUSED);
    req_chain[0].op    = op_i;
    req_chain[0].addr  = addr_i;
    req_chain[0].data  = data_in_i;
    req_chain[0].hit   = 1'b0;
    req_chain[0].rdata = '0;
  end

  // The newest entry enters at the head while every other entry moves one cell older.
  always_comb begin
    ent_chain[0].addr = addr_q;
    ent_chain[0].data = data_q;
    ent_chain[0].sync = (op_q == OP_PUT);
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign live[g] = (count_q > CNT_W'(g));
    frc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .live_i  (live[g]),
      .req_i   (req_chain[g]),
      .req_o   (req_chain[g+1]),
      .shift_i (shift),
      .entry_i (ent_chain[g]),
      .entry_o (ent_chain[g+1])
    );
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (op_i == OP_UNUSED) ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (req_chain[CAPACITY].vld) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (do_commit) begin
          state_d = ST_IDLE;
          if (do_insert && !full) begin
            count_d = count_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= op_i;
      addr_q  <= addr_i;
      data_q  <= data_in_i;
      hit_q   <= 1'b0;
      rdata_q <= '0;
    end else if ((state_q == ST_SCAN) && req_chain[CAPACITY].vld) begin
      hit_q   <= req_chain[CAPACITY].hit;
      rdata_q <= req_chain[CAPACITY].rdata;
    end
  end

  // Output register: the result waits here while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (do_commit) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_commit) begin
      hit_o       <= hit_q;
      read_data_o <= (op_q == OP_READ) ? rdata_q : '0;
      if (do_insert && full) begin
        evicted_o      <= 1'b1;
        evicted_addr_o <= ent_chain[CAPACITY].addr;
        evicted_data_o <= ent_chain[CAPACITY].data;
        evicted_sync_o <= ent_chain[CAPACITY].sync;
      end else begin
        evicted_o      <= 1'b0;
        evicted_addr_o <= '0;
        evicted_data_o <= '0;
        evicted_sync_o <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/frc_cell.sv @@
// One storage cell of the cache row: holds an entry and one hop of the lookup path.
`default_nettype none
module frc_cell
  import frc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       live_i,
  input  wire frc_req_t   req_i,
  output frc_req_t        req_o,
  input  wire logic       shift_i,
  input  wire frc_entry_t entry_i,
  output frc_entry_t      entry_o
);

  frc_req_t   req_d, req_q;
  frc_entry_t entry_q;
  logic       match;

  // Cells are ordered newest first, so the first match a request sees is the newest one.
  assign match = req_i.vld && live_i && (entry_q.addr == req_i.addr);

  always_comb begin
    req_d = req_i;
    if (match) begin
      req_d.hit = 1'b1;
      if (!req_i.hit) begin
        req_d.rdata = entry_q.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
    end else begin
      req_q <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end else if (match && (req_i.op == OP_WRITE)) begin
      entry_q.data <= req_i.data;
      entry_q.sync <= 1'b0;
    end
  end

  assign req_o   = req_q;
  assign entry_o = entry_q;

endmodule
`default_nettype wire

@@ rtl/frc_checker.sv @@
// Port-level assertions for the FIFO replacement cache, bound to the top level.
`default_nettype none
module frc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic               hit_o,
  input wire logic        [31:0] read_data_o,
  input wire logic               evicted_o,
  input wire logic signed [31:0] evicted_addr_o,
  input wire logic        [31:0] evicted_data_o,
  input wire logic               evicted_sync_o
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o) && $stable(read_data_o)
      && $stable(evicted_o) && $stable(evicted_addr_o) && $stable(evicted_data_o))
    else $error("stalled result changed");

  // One request at a time: an accepted request closes the input channel.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a request");

  // A miss never returns data.
  a_miss_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> (read_data_o == 32'd0))
    else $error("read data on a miss");

  // Without an eviction the evicted fields are zero.
  a_no_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_o |-> (evicted_addr_o == 32'sd0) && (evicted_data_o == 32'd0)
      && !evicted_sync_o)
    else $error("evicted fields set without an eviction");

endmodule

bind fifo_replacement_cache frc_checker u_frc_checker (.*);
`default_nettype wire
